### hdl/he_pkg.sv
// Shared types and constants for the histogram equalizer.
`timescale 1ns / 1ps
package he_pkg;

  localparam int GRAY_LEVELS_DEF = 256;
  localparam int COUNT_BITS_DEF  = 24;
  localparam int FUNC_W          = 2;
  localparam int PIXEL_W         = 8;
  localparam int MAP_W           = 16;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_COUNT = 2'd1,
    FUNC_BUILD = 2'd2,
    FUNC_MAP   = 2'd3
  } func_t;

endpackage

### hdl/he_stream_if.sv
// Valid/ready channel interfaces for the histogram equalizer.
`timescale 1ns / 1ps
interface he_in_if;
  logic                          valid;
  logic                          ready;
  he_pkg::func_t                 func;
  logic [he_pkg::PIXEL_W-1:0]    pixel;

  modport source (output valid, output func, output pixel, input ready);
  modport sink   (input valid, input func, input pixel, output ready);
endinterface

interface he_out_if;
  logic                        valid;
  logic                        ready;
  logic [he_pkg::MAP_W-1:0]    mapped_value;

  modport source (output valid, output mapped_value, input ready);
  modport sink   (input valid, input mapped_value, output ready);
endinterface

### hdl/he_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module he_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/histogram_equalizer_core.sv
// Histogram equalizer top level: level count memory, map memory and build sequencer.
`timescale 1ns / 1ps
// The block takes one word at a time. A count word reads and then writes its
// counter. A map word reads the map and then sits in an output register until it is
// taken, so the next word is accepted while that result waits; a map word that finds
// the register still full waits there. A clear word sweeps the count memory, and after
// reset the same sweep clears both memories before the first word is accepted. A build
// word scans the counts, then visits every level: a level inside the occupied span
// takes one read, one accumulate, one multiply, a restoring divider that yields one
// quotient bit a cycle, and one write; a level outside it takes a read, a span check
// and a write. When the histogram is empty or holds a single level, the scan is
// followed by a sweep that zeros the map instead.
// Words whose pixel is not below GRAY_LEVELS are not counted and map to zero.
module histogram_equalizer_core #(
  parameter int GRAY_LEVELS = he_pkg::GRAY_LEVELS_DEF,
  parameter int COUNT_BITS  = he_pkg::COUNT_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  he_in_if.sink    in_ch,
  he_out_if.source out_ch
);

  localparam int LVL_W  = $clog2(GRAY_LEVELS);
  localparam int IDX_W  = LVL_W + 1;
  localparam int SUM_W  = COUNT_BITS + LVL_W;
  localparam int PROD_W = SUM_W + LVL_W;
  localparam int QB     = LVL_W + 8;
  localparam int DC_W   = $clog2(QB);
  localparam logic [IDX_W-1:0]      NUM_IDX   = IDX_W'(GRAY_LEVELS);
  localparam logic [IDX_W-1:0]      LAST_IDX  = IDX_W'(GRAY_LEVELS - 1);
  localparam logic [LVL_W-1:0]      GM1       = LVL_W'(GRAY_LEVELS - 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [DC_W-1:0]       DC_LAST   = DC_W'(QB - 1);

  typedef enum logic [9:0] {
    S_CLR  = 10'b0000000001,
    S_IDLE = 10'b0000000010,
    S_CNT  = 10'b0000000100,
    S_MAP  = 10'b0000001000,
    S_SCAN = 10'b0000010000,
    S_MRD  = 10'b0000100000,
    S_MACC = 10'b0001000000,
    S_MMUL = 10'b0010000000,
    S_MDIV = 10'b0100000000,
    S_MWR  = 10'b1000000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic                    rv_r, rv_nxt;
  logic                    found_r, found_nxt;
  logic [LVL_W-1:0]        lo_r, lo_nxt;
  logic [LVL_W-1:0]        hi_r, hi_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [COUNT_BITS-1:0]   cntlo_r, cntlo_nxt;
  logic [SUM_W-1:0]        total_r, total_nxt;
  logic [SUM_W-1:0]        cum_r, cum_nxt;
  logic                    span_r, span_nxt;
  logic [SUM_W-1:0]        rem_r, rem_nxt;
  logic [QB-1:0]           low_r, low_nxt;
  logic [DC_W-1:0]         dcnt_r, dcnt_nxt;
  logic                    clr_cnt_r, clr_cnt_nxt;
  logic                    clr_map_r, clr_map_nxt;
  logic [LVL_W-1:0]        pix_r, pix_nxt;
  logic                    inr_r, inr_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [he_pkg::MAP_W-1:0] out_data_r, out_data_nxt;

  logic                    cnt_we, map_we;
  logic [LVL_W-1:0]        cnt_waddr, cnt_raddr, map_waddr, map_raddr;
  logic [COUNT_BITS-1:0]   cnt_wdata, cnt_rdata;
  logic [he_pkg::MAP_W-1:0] map_wdata, map_rdata;

  logic                    in_acc;
  logic                    in_range;
  logic [LVL_W-1:0]        in_addr;
  logic [LVL_W-1:0]        idx_addr;
  logic [LVL_W-1:0]        ridx;
  logic [PROD_W-1:0]       prod;
  logic [SUM_W:0]          trial;
  logic                    trial_ge;
  logic [he_pkg::MAP_W-1:0] q_sat;

  he_ram #(.WIDTH(COUNT_BITS), .DEPTH(GRAY_LEVELS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  he_ram #(.WIDTH(he_pkg::MAP_W), .DEPTH(GRAY_LEVELS)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  assign in_ch.ready         = (state_r == S_IDLE);
  assign in_acc              = in_ch.valid && in_ch.ready;
  assign in_range            = ({24'd0, in_ch.pixel} < 32'(GRAY_LEVELS));
  assign in_addr             = LVL_W'(in_ch.pixel);
  assign idx_addr            = idx_r[LVL_W-1:0];
  assign ridx                = LVL_W'(idx_r - IDX_W'(1));
  assign out_ch.valid        = out_valid_r;
  assign out_ch.mapped_value = out_data_r;

  assign prod     = PROD_W'(cum_r) * PROD_W'(GM1);
  assign trial    = {rem_r, low_r[QB-1]};
  assign trial_ge = (trial >= {1'b0, total_r});
  assign q_sat    = ({{(32 - QB){1'b0}}, low_r} > 32'h0000FFFF) ? 16'hFFFF
                                                                 : he_pkg::MAP_W'(low_r);

  // Memory ports.
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = idx_addr;
    cnt_wdata = '0;
    cnt_raddr = idx_addr;
    map_we    = 1'b0;
    map_waddr = idx_addr;
    map_wdata = '0;
    map_raddr = pix_r;
    unique case (state_r)
      S_CLR: begin
        cnt_we = clr_cnt_r;
        map_we = clr_map_r;
      end
      S_IDLE: begin
        cnt_raddr = in_addr;
        map_raddr = in_addr;
      end
      S_CNT: begin
        cnt_waddr = pix_r;
        cnt_we    = 1'b1;
        cnt_wdata = (cnt_rdata == COUNT_MAX) ? cnt_rdata : cnt_rdata + COUNT_BITS'(1);
      end
      S_MWR: begin
        map_we    = 1'b1;
        map_wdata = span_r ? q_sat : '0;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    rv_nxt        = rv_r;
    found_nxt     = found_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    sum_nxt       = sum_r;
    cntlo_nxt     = cntlo_r;
    total_nxt     = total_r;
    cum_nxt       = cum_r;
    span_nxt      = span_r;
    rem_nxt       = rem_r;
    low_nxt       = low_r;
    dcnt_nxt      = dcnt_r;
    clr_cnt_nxt   = clr_cnt_r;
    clr_map_nxt   = clr_map_r;
    pix_nxt       = pix_r;
    inr_nxt       = inr_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_CLR: begin
        idx_nxt = idx_r + IDX_W'(1);
        if (idx_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        pix_nxt = in_addr;
        inr_nxt = in_range;
        idx_nxt = '0;
        if (in_acc) begin
          unique case (in_ch.func)
            he_pkg::FUNC_CLEAR: begin
              clr_cnt_nxt = 1'b1;
              clr_map_nxt = 1'b0;
              state_nxt   = S_CLR;
            end
            he_pkg::FUNC_COUNT: begin
              if (in_range) begin
                state_nxt = S_CNT;
              end
            end
            he_pkg::FUNC_BUILD: begin
              rv_nxt    = 1'b0;
              found_nxt = 1'b0;
              sum_nxt   = '0;
              state_nxt = S_SCAN;
            end
            he_pkg::FUNC_MAP: begin
              state_nxt = S_MAP;
            end
            default: begin
            end
          endcase
        end
      end
      S_CNT: begin
        state_nxt = S_IDLE;
      end
      S_MAP: begin
        // The map address is held, so the read data stays put while the output waits.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = inr_r ? map_rdata : '0;
          state_nxt     = S_IDLE;
        end
      end
      S_SCAN: begin
        rv_nxt = (idx_r != NUM_IDX);
        if (idx_r != NUM_IDX) begin
          idx_nxt = idx_r + IDX_W'(1);
        end
        if (rv_r && (cnt_rdata != '0)) begin
          if (!found_r) begin
            lo_nxt    = ridx;
            cntlo_nxt = cnt_rdata;
          end
          found_nxt = 1'b1;
          hi_nxt    = ridx;
          sum_nxt   = sum_r + SUM_W'(cnt_rdata);
        end
        if (!rv_r && (idx_r == NUM_IDX)) begin
          idx_nxt   = '0;
          cum_nxt   = '0;
          total_nxt = sum_r - SUM_W'(cntlo_r);
          if (found_r && (lo_r != hi_r)) begin
            state_nxt = S_MRD;
          end else begin
            // Empty histogram or a single occupied level: the map is all zeros.
            clr_cnt_nxt = 1'b0;
            clr_map_nxt = 1'b1;
            state_nxt   = S_CLR;
          end
        end
      end
      S_MRD: begin
        state_nxt = S_MACC;
      end
      S_MACC: begin
        span_nxt = (idx_addr >= lo_r) && (idx_addr <= hi_r);
        if ((idx_addr > lo_r) && (idx_addr <= hi_r)) begin
          cum_nxt = cum_r + SUM_W'(cnt_rdata);
        end
        state_nxt = ((idx_addr >= lo_r) && (idx_addr <= hi_r)) ? S_MMUL : S_MWR;
      end
      S_MMUL: begin
        // The dividend is cum * (levels - 1) * 256; its top part is already below total.
        rem_nxt   = SUM_W'(prod >> LVL_W);
        low_nxt   = {prod[LVL_W-1:0], 8'd0};
        dcnt_nxt  = '0;
        state_nxt = S_MDIV;
      end
      S_MDIV: begin
        rem_nxt  = trial_ge ? SUM_W'(trial - {1'b0, total_r}) : SUM_W'(trial);
        low_nxt  = {low_r[QB-2:0], trial_ge};
        dcnt_nxt = dcnt_r + DC_W'(1);
        if (dcnt_r == DC_LAST) begin
          state_nxt = S_MWR;
        end
      end
      S_MWR: begin
        idx_nxt   = idx_r + IDX_W'(1);
        state_nxt = (idx_r == LAST_IDX) ? S_IDLE : S_MRD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      idx_r       <= '0;
      rv_r        <= 1'b0;
      found_r     <= 1'b0;
      clr_cnt_r   <= 1'b1;
      clr_map_r   <= 1'b1;
      dcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      rv_r        <= rv_nxt;
      found_r     <= found_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      clr_map_r   <= clr_map_nxt;
      dcnt_r      <= dcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    sum_r      <= sum_nxt;
    cntlo_r    <= cntlo_nxt;
    total_r    <= total_nxt;
    cum_r      <= cum_nxt;
    span_r     <= span_nxt;
    rem_r      <= rem_nxt;
    low_r      <= low_nxt;
    pix_r      <= pix_nxt;
    inr_r      <= inr_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### hdl/he_checker.sv
// Port-level checks for the histogram equalizer, bound to the top level.
`timescale 1ns / 1ps
module he_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input he_pkg::func_t              in_func,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [he_pkg::MAP_W-1:0]   out_mapped_value
);

  // A result word holds while the consumer stalls.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mapped_value))
    else $error("result word changed while stalled");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // Every word other than a count keeps the block busy after it is accepted.
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func != he_pkg::FUNC_COUNT) |=> !in_ready)
    else $error("block ready right after a multi-cycle word");

  // A new result appears only when the block was busy in the cycle before, as on a map word.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a pending map word");

endmodule

bind histogram_equalizer_core he_checker u_he_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_func          (in_ch.func),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_mapped_value (out_ch.mapped_value)
);

### sim/he_checker.sv
// Checker for the histogram equalizer: predicts mapped values and compares results.
`timescale 1ns / 1ps
module he_scoreboard #(
  parameter int GRAY_LEVELS = he_pkg::GRAY_LEVELS_DEF,
  parameter int COUNT_BITS  = he_pkg::COUNT_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  he_in_if.sink    in_mon,
  he_out_if.sink   out_mon,
  output int       fail_count,
  output int       pending_count
);

  localparam longint COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
  localparam longint MAP_SCALE = longint'(GRAY_LEVELS - 1) * 256;

  longint                     hist[GRAY_LEVELS];
  logic [he_pkg::MAP_W-1:0]   eq_map[GRAY_LEVELS];
  logic [he_pkg::MAP_W-1:0]   mapped_q[$];

  // Rebuilds the equalization map from the current histogram.
  task automatic rebuild_map();
    int lo, hi;
    longint cum, total, q;
    lo = -1;
    hi = -1;
    for (int v = 0; v < GRAY_LEVELS; v++) begin
      eq_map[v] = '0;
      if (hist[v] != 0) begin
        if (lo < 0) lo = v;
        hi = v;
      end
    end
    if (lo < 0 || lo == hi) return;
    total = 0;
    for (int v = lo + 1; v <= hi; v++) total += hist[v];
    if (total == 0) return;
    cum = 0;
    for (int v = lo; v <= hi; v++) begin
      if (v > lo) cum += hist[v];
      q = (cum * MAP_SCALE) / total;
      eq_map[v] = (q > 65535) ? 16'hFFFF : q[he_pkg::MAP_W-1:0];
    end
  endtask

  assign pending_count = mapped_q.size();

  always @(posedge clk) begin
    if (!rst_n) begin
      fail_count <= 0;
      mapped_q.delete();
      for (int v = 0; v < GRAY_LEVELS; v++) begin
        hist[v] = 0;
        eq_map[v] = '0;
      end
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (mapped_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual mapped_value %0d",
                   $time, out_mon.mapped_value);
          fail_count <= fail_count + 1;
        end else begin
          logic [he_pkg::MAP_W-1:0] want;
          want = mapped_q.pop_front();
          if (out_mon.mapped_value !== want) begin
            $display("%0t: mapped_value mismatch, expected %0d, actual %0d",
                     $time, want, out_mon.mapped_value);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.func)
          he_pkg::FUNC_CLEAR: for (int v = 0; v < GRAY_LEVELS; v++) hist[v] = 0;
          he_pkg::FUNC_COUNT:
            if (in_mon.pixel < GRAY_LEVELS && hist[in_mon.pixel] < COUNT_MAX)
              hist[in_mon.pixel]++;
          he_pkg::FUNC_BUILD: rebuild_map();
          default:
            mapped_q.push_back((in_mon.pixel < GRAY_LEVELS) ? eq_map[in_mon.pixel] : '0);
        endcase
      end
    end
  end
endmodule

### sim/tb.sv
// Testbench top for the histogram equalizer: stimulus, idling phases and verdict.
`timescale 1ns / 1ps
module tb;

  localparam int IDLE_LIMIT  = 20000;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   idle_cycles;

  he_in_if  in_ch();
  he_out_if out_ch();

  histogram_equalizer_core u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));
  he_scoreboard u_checker (.clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
                           .fail_count(fail_count), .pending_count(pending_count));

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver stalls at random, by the current phase's rate.
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles without any accepted word.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Valid stays high from one word to the next unless the sender idles in between.
  task automatic send_word(input he_pkg::func_t f, input logic [he_pkg::PIXEL_W-1:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= f;
    in_ch.pixel <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // A frame: maybe clear, count mostly in a narrow or wide band, maybe build, map.
  task automatic run_frame(input int n_count, input int n_map);
    int lo, hi;
    lo = $urandom_range(255);
    hi = ($urandom_range(3) == 0) ? lo : $urandom_range(255, lo);
    if ($urandom_range(7) != 0) send_word(he_pkg::FUNC_CLEAR, he_pkg::PIXEL_W'($urandom));
    for (int i = 0; i < n_count; i++)
      send_word(he_pkg::FUNC_COUNT,
                ($urandom_range(9) == 0) ? he_pkg::PIXEL_W'($urandom)
                                         : he_pkg::PIXEL_W'($urandom_range(hi, lo)));
    if ($urandom_range(9) != 0) send_word(he_pkg::FUNC_BUILD, he_pkg::PIXEL_W'($urandom));
    for (int i = 0; i < n_map; i++) send_word(he_pkg::FUNC_MAP, he_pkg::PIXEL_W'($urandom));
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = he_pkg::FUNC_CLEAR;
    in_ch.pixel = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: map before any build, empty build, single level, extremes.
    send_word(he_pkg::FUNC_MAP, 8'd0);
    send_word(he_pkg::FUNC_MAP, 8'd255);
    send_word(he_pkg::FUNC_BUILD, 8'd0);
    send_word(he_pkg::FUNC_MAP, 8'd128);
    send_word(he_pkg::FUNC_COUNT, 8'd77);
    send_word(he_pkg::FUNC_COUNT, 8'd77);
    send_word(he_pkg::FUNC_BUILD, 8'd0);
    send_word(he_pkg::FUNC_MAP, 8'd77);
    send_word(he_pkg::FUNC_COUNT, 8'd0);
    send_word(he_pkg::FUNC_COUNT, 8'd255);
    send_word(he_pkg::FUNC_COUNT, 8'd170);
    send_word(he_pkg::FUNC_COUNT, 8'd85);
    send_word(he_pkg::FUNC_BUILD, 8'hFF);
    send_word(he_pkg::FUNC_MAP, 8'd0);
    send_word(he_pkg::FUNC_MAP, 8'd85);
    send_word(he_pkg::FUNC_MAP, 8'd170);
    send_word(he_pkg::FUNC_MAP, 8'd255);
    send_word(he_pkg::FUNC_MAP, 8'd100);
    // The map keeps its values after the histogram is cleared.
    send_word(he_pkg::FUNC_CLEAR, 8'd0);
    send_word(he_pkg::FUNC_MAP, 8'd255);
    send_word(he_pkg::FUNC_MAP, 8'd85);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      for (int f = 0; f < 15; f++)
        run_frame($urandom_range(40, 1), $urandom_range(12, 4));
    end
    in_ch.valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
